@@ src/cpt_pkg.sv @@
package cpt_pkg;

    localparam int POS_BITS   = 16;
    localparam int CODE_W     = 6;
    localparam int LEN_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int RES_W      = CODE_W + POS_BITS + LEN_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_PCT    = 8'h25;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_BSL    = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;

    typedef enum logic [4:0] {
        P_NONE, P_CARET, P_BANG, P_EQ, P_AMP, P_BAR, P_DOT, P_DOT2, P_PLUS,
        P_MINUS, P_STAR, P_SLASH, P_PCT, P_LT, P_LT2, P_GT, P_GT2, P_BSL
    } prefix_t;

    typedef enum logic [CODE_W-1:0] {
        T_COMMA, T_SEMI, T_QUEST, T_COLON, T_TILDE, T_LPAREN, T_RPAREN,
        T_LBRACE, T_RBRACE, T_LBRACK, T_RBRACK, T_CARET, T_CARET_EQ,
        T_BANG, T_BANG_EQ, T_EQ, T_EQ_EQ, T_AMP, T_AMP_EQ, T_AMP_AMP,
        T_BAR, T_BAR_EQ, T_BAR_BAR, T_DOT, T_ELLIPSIS, T_PLUS, T_PLUS_PLUS,
        T_PLUS_EQ, T_MINUS, T_ARROW, T_MINUS_MINUS, T_MINUS_EQ, T_STAR,
        T_STAR_EQ, T_SLASH, T_SLASH_EQ, T_PCT, T_PCT_EQ, T_LT, T_LT_EQ,
        T_SHL, T_SHL_EQ, T_GT, T_GT_EQ, T_SHR, T_SHR_EQ, T_NUMBER,
        T_COMMENT, T_OTHER, T_BAD_BSL, T_TWO_DOTS
    } tok_t;

    typedef enum logic [1:0] {
        EXT_NONE, EXT_DONE, EXT_LONGER, EXT_SPLICE
    } ext_kind_t;

    typedef struct packed {
        logic    hold;
        prefix_t pfx;
        tok_t    code;
    } fresh_t;

    typedef struct packed {
        ext_kind_t kind;
        tok_t      code;
        prefix_t   next;
    } ext_t;

    typedef struct packed {
        tok_t                code;
        logic [POS_BITS-1:0] pos;
        logic [LEN_W-1:0]    len;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    function automatic fresh_t classify_fresh(input logic [BYTE_W-1:0] b);
        fresh_t f;
        f.hold = 1'b1;
        f.pfx  = P_NONE;
        f.code = T_OTHER;
        unique case (b)
            CH_COMMA:  begin f.hold = 1'b0; f.code = T_COMMA;  end
            CH_SEMI:   begin f.hold = 1'b0; f.code = T_SEMI;   end
            CH_QUEST:  begin f.hold = 1'b0; f.code = T_QUEST;  end
            CH_COLON:  begin f.hold = 1'b0; f.code = T_COLON;  end
            CH_TILDE:  begin f.hold = 1'b0; f.code = T_TILDE;  end
            CH_LPAREN: begin f.hold = 1'b0; f.code = T_LPAREN; end
            CH_RPAREN: begin f.hold = 1'b0; f.code = T_RPAREN; end
            CH_LBRACE: begin f.hold = 1'b0; f.code = T_LBRACE; end
            CH_RBRACE: begin f.hold = 1'b0; f.code = T_RBRACE; end
            CH_LBRACK: begin f.hold = 1'b0; f.code = T_LBRACK; end
            CH_RBRACK: begin f.hold = 1'b0; f.code = T_RBRACK; end
            CH_CARET:  f.pfx = P_CARET;
            CH_BANG:   f.pfx = P_BANG;
            CH_EQ:     f.pfx = P_EQ;
            CH_AMP:    f.pfx = P_AMP;
            CH_BAR:    f.pfx = P_BAR;
            CH_DOT:    f.pfx = P_DOT;
            CH_PLUS:   f.pfx = P_PLUS;
            CH_MINUS:  f.pfx = P_MINUS;
            CH_STAR:   f.pfx = P_STAR;
            CH_SLASH:  f.pfx = P_SLASH;
            CH_PCT:    f.pfx = P_PCT;
            CH_LT:     f.pfx = P_LT;
            CH_GT:     f.pfx = P_GT;
            CH_BSL:    f.pfx = P_BSL;
            default:   begin f.hold = 1'b0; f.code = T_OTHER; end
        endcase
        return f;
    endfunction

    function automatic ext_t extend_prefix(input prefix_t p, input logic [BYTE_W-1:0] b);
        ext_t e;
        e.kind = EXT_NONE;
        e.code = T_OTHER;
        e.next = P_NONE;
        unique case (p)
            P_CARET: if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_CARET_EQ; end
            P_BANG:  if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_BANG_EQ; end
            P_EQ:    if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_EQ_EQ; end
            P_AMP:
            begin
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_AMP_EQ; end
                if (b == CH_AMP) begin e.kind = EXT_DONE; e.code = T_AMP_AMP; end
            end
            P_BAR:
            begin
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_BAR_EQ; end
                if (b == CH_BAR) begin e.kind = EXT_DONE; e.code = T_BAR_BAR; end
            end
            P_DOT:
            begin
                if (b == CH_DOT) begin e.kind = EXT_LONGER; e.next = P_DOT2; end
                if (b >= CH_0 && b <= CH_9) begin e.kind = EXT_DONE; e.code = T_NUMBER; end
            end
            P_DOT2:  if (b == CH_DOT) begin e.kind = EXT_DONE; e.code = T_ELLIPSIS; end
            P_PLUS:
            begin
                if (b == CH_PLUS) begin e.kind = EXT_DONE; e.code = T_PLUS_PLUS; end
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_PLUS_EQ; end
            end
            P_MINUS:
            begin
                if (b == CH_GT) begin e.kind = EXT_DONE; e.code = T_ARROW; end
                if (b == CH_MINUS) begin e.kind = EXT_DONE; e.code = T_MINUS_MINUS; end
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_MINUS_EQ; end
            end
            P_STAR:  if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_STAR_EQ; end
            P_SLASH:
            begin
                if (b == CH_SLASH || b == CH_STAR)
                begin
                    e.kind = EXT_DONE;
                    e.code = T_COMMENT;
                end
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_SLASH_EQ; end
            end
            P_PCT:   if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_PCT_EQ; end
            P_LT:
            begin
                if (b == CH_LT) begin e.kind = EXT_LONGER; e.next = P_LT2; end
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_LT_EQ; end
            end
            P_LT2:   if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_SHL_EQ; end
            P_GT:
            begin
                if (b == CH_GT) begin e.kind = EXT_LONGER; e.next = P_GT2; end
                if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_GT_EQ; end
            end
            P_GT2:   if (b == CH_EQ) begin e.kind = EXT_DONE; e.code = T_SHR_EQ; end
            P_BSL:   if (b == CH_NL) e.kind = EXT_SPLICE;
            default: e.kind = EXT_NONE;
        endcase
        return e;
    endfunction

    function automatic tok_t flush_code(input prefix_t p);
        tok_t c;
        unique case (p)
            P_CARET: c = T_CARET;
            P_BANG:  c = T_BANG;
            P_EQ:    c = T_EQ;
            P_AMP:   c = T_AMP;
            P_BAR:   c = T_BAR;
            P_DOT:   c = T_DOT;
            P_DOT2:  c = T_TWO_DOTS;
            P_PLUS:  c = T_PLUS;
            P_MINUS: c = T_MINUS;
            P_STAR:  c = T_STAR;
            P_SLASH: c = T_SLASH;
            P_PCT:   c = T_PCT;
            P_LT:    c = T_LT;
            P_LT2:   c = T_SHL;
            P_GT:    c = T_GT;
            P_GT2:   c = T_SHR;
            P_BSL:   c = T_BAD_BSL;
            default: c = T_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] flush_len(input prefix_t p);
        logic [LEN_W-1:0] l;
        unique case (p)
            P_NONE:                l = 2'd0;
            P_DOT2, P_LT2, P_GT2:  l = 2'd2;
            default:               l = 2'd1;
        endcase
        return l;
    endfunction

endpackage

@@ src/cpt_front.sv @@
module cpt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cpt_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_end,
    input  cpt_pkg::q_stat_t           q_stat,
    output cpt_pkg::push_t             push
);

    cpt_pkg::prefix_t                pend_reg, pend_next;
    logic [cpt_pkg::POS_BITS-1:0]    pstart_reg, pstart_next;
    logic [cpt_pkg::POS_BITS-1:0]    pos_reg, pos_next;
    logic                            accept;
    cpt_pkg::fresh_t                 fr;
    cpt_pkg::ext_t                   ex;
    cpt_pkg::result_t                flush_res;
    cpt_pkg::result_t                fresh_res;
    logic                            n_any;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fr = cpt_pkg::classify_fresh(in_byte);
        ex = cpt_pkg::extend_prefix(pend_reg, in_byte);

        flush_res.code = cpt_pkg::flush_code(pend_reg);
        flush_res.pos  = pstart_reg;
        flush_res.len  = cpt_pkg::flush_len(pend_reg);

        fresh_res.code = fr.code;
        fresh_res.pos  = pos_reg;
        fresh_res.len  = 2'd1;

        pend_next   = pend_reg;
        pstart_next = pstart_reg;
        pos_next    = pos_reg;
        n_any       = 1'b0;
        push.entry.two = 1'b0;
        push.entry.r0  = flush_res;
        push.entry.r1  = fresh_res;

        if (in_end)
        begin
            n_any     = (pend_reg != cpt_pkg::P_NONE);
            pend_next = cpt_pkg::P_NONE;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            if (pend_reg == cpt_pkg::P_NONE)
            begin
                if (fr.hold)
                begin
                    pend_next   = fr.pfx;
                    pstart_next = pos_reg;
                end
                else
                begin
                    n_any         = 1'b1;
                    push.entry.r0 = fresh_res;
                end
            end
            else
            begin
                unique case (ex.kind)
                    cpt_pkg::EXT_DONE:
                    begin
                        n_any              = 1'b1;
                        push.entry.r0.code = ex.code;
                        push.entry.r0.len  = flush_res.len + 2'd1;
                        pend_next          = cpt_pkg::P_NONE;
                    end
                    cpt_pkg::EXT_LONGER: pend_next = ex.next;
                    cpt_pkg::EXT_SPLICE: pend_next = cpt_pkg::P_NONE;
                    default:
                    begin
                        // emit the shorter token, then treat the byte afresh
                        n_any     = 1'b1;
                        pend_next = cpt_pkg::P_NONE;
                        if (fr.hold)
                        begin
                            pend_next   = fr.pfx;
                            pstart_next = pos_reg;
                        end
                        else
                        begin
                            push.entry.two = 1'b1;
                        end
                    end
                endcase
            end
        end
        push.valid = accept && n_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= cpt_pkg::P_NONE;
            pstart_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            pend_reg   <= pend_next;
            pstart_reg <= pstart_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

@@ src/cpt_queue.sv @@
module cpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  cpt_pkg::push_t    push,
    input  logic              pop,
    output cpt_pkg::q_stat_t  q_stat,
    output cpt_pkg::entry_t   head
);

    cpt_pkg::entry_t                mem_reg [cpt_pkg::QDEPTH];
    logic [cpt_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cpt_pkg::QPTR_W:0]       count_reg, count_next;
    logic                           do_pop;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == (cpt_pkg::QPTR_W+1)'(cpt_pkg::QDEPTH));
    assign head             = mem_reg[rd_ptr_reg];
    assign do_pop           = pop && q_stat.not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

endmodule

@@ src/cpt_back.sv @@
module cpt_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpt_pkg::q_stat_t               q_stat,
    input  cpt_pkg::entry_t                head,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    logic             second_reg, second_next;
    logic             out_xfer;
    cpt_pkg::result_t cur;

    assign m_axis_tvalid = q_stat.not_empty;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign cur           = second_reg ? head.r1 : head.r0;
    assign m_axis_tlast  = second_reg || !head.two;
    assign pop           = out_xfer && m_axis_tlast;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[cpt_pkg::CODE_W-1:0] = cur.code;
        m_axis_tdata[cpt_pkg::CODE_W +: cpt_pkg::POS_BITS] = cur.pos;
        m_axis_tdata[cpt_pkg::CODE_W + cpt_pkg::POS_BITS +: cpt_pkg::LEN_W] = cur.len;
    end

    always_comb
    begin
        second_next = second_reg;
        if (out_xfer)
            second_next = !m_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

endmodule

@@ src/c_punctuator_tokenizer.sv @@
// A result is written into the queue when the byte that completes it is accepted, then offered.
// Throughput: one byte per cycle while the queue is not full; an entry with two results leaves
// as two transfers; a four-entry queue between classifier and output absorbs the difference.
// Reset (rst_n low, asynchronous): no prefix pending, positions zero, queue empty.
module c_punctuator_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // byte_in
    input  logic                           s_axis_tuser,   // end_of_input
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // token_code[5:0], start_pos[21:6], token_len[23:22]
    output logic [cpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast    // last_result
);

    cpt_pkg::push_t   push;
    cpt_pkg::q_stat_t q_stat;
    cpt_pkg::entry_t  head;
    logic             pop;

    cpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_end   (s_axis_tuser),
        .q_stat   (q_stat),
        .push     (push)
    );

    cpt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    cpt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // first result of a pair leaves its partner waiting
    a_pair_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a pair missing");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> s_axis_tready)
        else $error("queue written while full");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[cpt_pkg::CODE_W + cpt_pkg::POS_BITS +: cpt_pkg::LEN_W] != '0)
        else $error("token with zero length");

    a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && !q_stat.not_empty))
        else $error("queue full and empty");

endmodule
